/* rtl/core/b64e_pkg.sv */
`default_nettype none
package b64e_pkg;

	localparam int QUEUE_DEPTH = 4;

	// Sextet index that selects the pad character
	localparam logic [6:0] PAD_INDEX = 7'd64;

	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
	localparam logic [7:0] ASCII_DIGIT_0 = 8'h30;
	localparam logic [7:0] ASCII_DIGIT_9 = 8'h39;
	localparam logic [7:0] ASCII_PLUS    = 8'h2B;
	localparam logic [7:0] ASCII_SLASH   = 8'h2F;
	localparam logic [7:0] ASCII_PAD     = 8'h3D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} symbol_t;

	// One 24-bit group ready for output; filled is the byte count (1 to 3)
	typedef struct packed {
		logic [23:0] group;
		logic [1:0]  filled;
		logic        last;
	} group_t;

	function automatic logic [7:0] char_of(input logic [6:0] idx);
		logic [7:0] c;
		logic [7:0] i8;
		i8 = {1'b0, idx};
		if (idx < 7'd26)
			c = ASCII_UPPER_A + i8;
		else if (idx < 7'd52)
			c = ASCII_LOWER_A + i8 - 8'd26;
		else if (idx < 7'd62)
			c = ASCII_DIGIT_0 + i8 - 8'd52;
		else if (idx == 7'd62)
			c = ASCII_PLUS;
		else if (idx == 7'd63)
			c = ASCII_SLASH;
		else
			c = ASCII_PAD;
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/b64e_front.sv */
`default_nettype none
module b64e_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   accept,
	input  b64e_pkg::item_t       item,
	output logic                  enq,
	output b64e_pkg::group_t      grp
);

	logic [15:0] held_q;
	logic [1:0]  count_q;
	logic        hold;

	// Byte joins the open group unless it closes it
	assign hold = (count_q < 2'd2) && !item.last_byte;
	assign enq  = accept && !hold;

	always_comb begin
		grp.last = item.last_byte;
		case (count_q)
			2'd0: begin
				grp.group  = {item.data_byte, 16'h0000};
				grp.filled = 2'd1;
			end
			2'd1: begin
				grp.group  = {held_q[7:0], item.data_byte, 8'h00};
				grp.filled = 2'd2;
			end
			default: begin
				grp.group  = {held_q, item.data_byte};
				grp.filled = 2'd3;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (hold) begin
				held_q  <= {held_q[7:0], item.data_byte};
				count_q <= count_q + 2'd1;
			end else begin
				held_q  <= '0;
				count_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/b64e_queue.sv */
`default_nettype none
module b64e_queue #(
	parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   enq,
	input  b64e_pkg::group_t      wdata,
	output logic                  full,
	input  wire                   deq,
	output b64e_pkg::group_t      head,
	output logic                  head_vld
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64e_pkg::group_t mem [DEPTH];

	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          head_vld_q;
	logic          head_free, load_mem, load_byp, to_mem;

	// the head register is a show-ahead stage in front of the storage array
	assign head_free = !head_vld_q || deq;
	assign load_mem  = head_free && (cnt_q != '0);
	assign load_byp  = head_free && (cnt_q == '0) && enq;
	assign to_mem    = enq && !load_byp;
	assign full      = ({1'b0, cnt_q} + {{CW{1'b0}}, head_vld_q}) == (CW+1)'(DEPTH);
	assign head_vld  = head_vld_q;

	always_ff @(posedge clk) begin
		if (to_mem)
			mem[wr_ptr_q] <= wdata;
		if (load_mem)
			head <= mem[rd_ptr_q];
		else if (load_byp)
			head <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			cnt_q      <= '0;
			head_vld_q <= 1'b0;
		end else begin
			if (to_mem)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (load_mem)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (to_mem && !load_mem)
				cnt_q <= cnt_q + CW'(1);
			else if (load_mem && !to_mem)
				cnt_q <= cnt_q - CW'(1);
			if (head_free)
				head_vld_q <= load_mem || load_byp;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/b64e_back.sv */
`default_nettype none
module b64e_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  b64e_pkg::group_t      head,
	input  wire                   head_vld,
	output logic                  deq,
	input  wire                   pop,
	output logic                  empty,
	output b64e_pkg::symbol_t     symbol
);

	logic [1:0] k_q;
	logic       out_vld_q;
	logic       adv, emit;
	logic [5:0] sextet;
	logic [6:0] idx;

	assign adv   = !out_vld_q || pop;
	assign emit  = adv && head_vld;
	assign deq   = emit && (k_q == 2'd3);
	assign empty = !out_vld_q;

	always_comb begin
		case (k_q)
			2'd0:    sextet = head.group[23:18];
			2'd1:    sextet = head.group[17:12];
			2'd2:    sextet = head.group[11:6];
			default: sextet = head.group[5:0];
		endcase
		// positions past the last byte carry no message bits
		idx = (k_q > head.filled) ? b64e_pkg::PAD_INDEX : {1'b0, sextet};
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			symbol.char_code <= b64e_pkg::char_of(idx);
			symbol.last_char <= head.last && (k_q == 2'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv)
				out_vld_q <= head_vld;
			if (emit)
				k_q <= k_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/base64_stream_encoder_core.sv */
// Base64 stream encoder (standard alphabet, '=' padding).
// Input channel: push/full carries one byte per beat in item, with
// last_byte set on the final byte of a message. A beat is taken at a
// clock edge with push high and full low.
// Result channel: empty/pop. While empty is low, symbol holds the oldest
// character; it leaves at an edge with pop high. Each group of three
// bytes, or the shorter group closed by last_byte, yields four beats;
// the fourth beat of a closing group has last_char set.
// The first character of a group passes the queue's head register and
// then the output register before it shows on symbol.
// The output side runs one character per cycle while pop keeps up and
// the queue holds a group, so a long message yields four characters per
// three bytes and a stream of one-byte messages four per byte. The character
// serializer sets that rate; a group queue of QUEUE_DEPTH entries sits
// between the byte packer and the serializer.
// Reset clears the partial group, the queue and the output stage; empty
// goes high and full low. When pop is held low the output stage keeps its
// beat, the queue fills and full rises until the receiver resumes.
`default_nettype none
module base64_stream_encoder_core #(
	parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	output logic                  full,
	input  b64e_pkg::item_t       item,
	output logic                  empty,
	input  wire                   pop,
	output b64e_pkg::symbol_t     symbol
);

	logic             accept;
	logic             enq, deq, head_vld;
	b64e_pkg::group_t grp, head;

	assign accept = push && !full;

	// front: packs bytes into groups
	b64e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.enq    (enq),
		.grp    (grp)
	);

	// group queue between packer and serializer
	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (enq),
		.wdata    (grp),
		.full     (full),
		.deq      (deq),
		.head     (head),
		.head_vld (head_vld)
	);

	// back: four characters per group, one per cycle while pop is high
	b64e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_vld (head_vld),
		.deq      (deq),
		.pop      (pop),
		.empty    (empty),
		.symbol   (symbol)
	);

endmodule
`default_nettype wire

/* rtl/core/b64e_checker.sv */
`default_nettype none
module b64e_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   push,
	input wire                   full,
	input b64e_pkg::item_t       item,
	input wire                   empty,
	input wire                   pop,
	input b64e_pkg::symbol_t     symbol
);

	logic       in_acc, out_acc;
	logic [7:0] pend_q;
	logic       prev_pad_q;
	logic [7:0] c;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;
	assign c       = symbol.char_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			prev_pad_q <= 1'b0;
		end else begin
			pend_q <= pend_q + {7'd0, in_acc && item.last_byte}
				- {7'd0, out_acc && symbol.last_char};
			if (out_acc)
				prev_pad_q <= (c == b64e_pkg::ASCII_PAD) && !symbol.last_char;
		end
	end

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result side not empty in reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(symbol))
		else $error("stalled beat changed");

	a_last_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && symbol.last_char |-> pend_q != 8'd0)
		else $error("last_char without a closing byte");

	a_pad_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && prev_pad_q |-> c == b64e_pkg::ASCII_PAD)
		else $error("data character after pad");

	a_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (c >= b64e_pkg::ASCII_UPPER_A && c <= b64e_pkg::ASCII_UPPER_Z)
			|| (c >= b64e_pkg::ASCII_LOWER_A && c <= b64e_pkg::ASCII_LOWER_Z)
			|| (c >= b64e_pkg::ASCII_DIGIT_0 && c <= b64e_pkg::ASCII_DIGIT_9)
			|| c == b64e_pkg::ASCII_PLUS || c == b64e_pkg::ASCII_SLASH
			|| c == b64e_pkg::ASCII_PAD)
		else $error("character outside alphabet");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (.*);
`default_nettype wire

/* test/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Encoding table, first character in the top byte; index 64 is the pad.
	localparam logic [8*65-1:0] B64_CHARS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";

	localparam int LONG_HOLD = 80;   // receiver hold-off used to back the block up
	localparam int SETTLE    = 8;    // cycles past the last beat before the verdict

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	b64e_pkg::item_t   item;
	logic              empty;
	logic              pop;
	b64e_pkg::symbol_t symbol;

	base64_stream_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.symbol (symbol)
	);

	// Encoder mirror: open group and the characters still owed by the block.
	logic [15:0]       held_bytes;
	int                held_cnt;
	b64e_pkg::symbol_t char_q[$];

	// Random idling switches for each side, and a one-shot long hold-off.
	bit tx_idle;
	bit rx_idle;
	int rx_hold;

	int n_bytes;
	int n_msgs;
	int n_chars;
	int n_full_cycles;
	int n_bad;

	always #10 clk = ~clk;

	initial begin
		clk     = 1'b0;
		arst_n  = 1'b0;
		push    = 1'b0;
		item    = '0;
		pop     = 1'b0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		rx_hold = 0;
	end

	// Mirror of the encoder for one accepted byte. Bytes pile up until the
	// group holds three or the message ends; then four characters are owed.
	function automatic void encode_byte(input logic [7:0] d, input logic l);
		logic [23:0]       grp;
		logic [6:0]        idx;
		int                filled;
		b64e_pkg::symbol_t s;
		if (held_cnt < 2 && !l) begin
			held_bytes = {held_bytes[7:0], d};
			held_cnt++;
			return;
		end
		filled = held_cnt + 1;
		grp = {held_bytes, d};
		// left-justify a short group; the vacated bits are zero
		grp = grp << ((3 - filled) * 8);
		for (int k = 0; k < 4; k++) begin
			// positions past the last byte's bits become '='
			if (k > filled)
				idx = b64e_pkg::PAD_INDEX;
			else
				idx = {1'b0, grp[(3 - k) * 6 +: 6]};
			s.char_code = B64_CHARS[8 * (64 - idx) +: 8];
			s.last_char = l && (k == 3);
			char_q.push_back(s);
		end
		held_bytes = '0;
		held_cnt   = 0;
	endfunction

	// One input beat. push stays high from the previous beat when no gap is
	// drawn, so back-to-back bytes really go out on consecutive cycles.
	task automatic send_byte(input logic [7:0] d, input logic l);
		int gap;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push           <= 1'b1;
		item.data_byte <= d;
		item.last_byte <= l;
		do @(posedge clk); while (full);
		encode_byte(d, l);
		n_bytes++;
		if (l)
			n_msgs++;
	endtask

	// Drop push before anything that spends time outside send_byte.
	task automatic quiet_input();
		@(negedge clk);
		push <= 1'b0;
	endtask

	// Sender pause: nothing goes in until every owed character came out.
	task automatic wait_all_chars();
		quiet_input();
		while (char_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Mostly random bytes, with the all-zero and all-one values thrown in
	// often enough to hit 'A' and '/' runs and their pad neighbors.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_byte(pick_byte(), i == len - 1);
	endtask

	// Receiver: per beat, an optional random stall, or the long hold-off once
	// a test arms it. pop stays up while waiting for the block to have a beat.
	initial begin : receiver
		int stall;
		@(posedge arst_n);
		forever begin
			stall = rx_idle ? $urandom_range(0, 15) : 0;
			if (rx_hold > 0) begin
				stall   = rx_hold;
				rx_hold = 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// Scoreboard: every character that leaves is matched against the oldest
	// owed one, both fields.
	always @(posedge clk) begin : check_chars
		b64e_pkg::symbol_t want;
		if (arst_n && push && full)
			n_full_cycles++;
		if (arst_n && pop && !empty) begin
			n_chars++;
			if (char_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("%0t: unexpected beat char=%02h last=%0b",
						$realtime, symbol.char_code, symbol.last_char);
			end else begin
				want = char_q.pop_front();
				if (symbol.char_code !== want.char_code ||
						symbol.last_char !== want.last_char) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: mismatch char exp=%02h got=%02h last exp=%0b got=%0b",
							$realtime, want.char_code, symbol.char_code,
							want.last_char, symbol.last_char);
				end
			end
		end
	end

	// Extremes and padding: one- and two-byte tails, '+' and '/' runs, a full
	// group that is not the end of its message, and a message right after one
	// that just closed.
	task automatic test_directed();
		send_byte(8'hFF, 1'b1);                            // "/w=="
		send_byte(8'h00, 1'b1);                            // "AA=="
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);                            // "//8="
		send_byte(8'hFB, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBE, 1'b1);                            // "++++"
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);                            // "AAAA"
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);                            // group closes, no flag
		send_byte(8'h00, 1'b1);                            // "////AA=="
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b0);
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b1);                            // "TWFuTWE="
	endtask

	// Random messages, mostly short so that every tail length recurs often,
	// now and then a long one.
	task automatic test_random_messages(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(8, 24);
			else
				len = $urandom_range(1, 7);
			send_message(len);
			sent += len;
		end
	endtask

	// Receiver stops for a long stretch while the sender streams without
	// gaps: the group queue fills and full must hold the input off.
	task automatic test_backpressure();
		tx_idle = 1'b0;
		rx_hold = LONG_HOLD;
		send_message(10);
		send_message(2);
		send_message(13);
		wait_all_chars();
		tx_idle = 1'b1;
	endtask

	// A stretch with no idling on either side.
	task automatic test_full_rate();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_message(1);
		send_message(1);
		send_message(9);
		send_message(5);
		send_message(4);
		wait_all_chars();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin : main
		held_bytes    = '0;
		held_cnt      = 0;
		n_bytes       = 0;
		n_msgs        = 0;
		n_chars       = 0;
		n_full_cycles = 0;
		n_bad         = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		wait_all_chars();
		test_random_messages(60);
		test_backpressure();
		test_full_rate();
		test_random_messages(40);
		wait_all_chars();

		// anything still owed never came out
		n_bad += char_q.size();
		$display("Encoded %0d bytes in %0d messages, %0d characters compared;",
			n_bytes, n_msgs, n_chars);
		$display("input held off by full on %0d cycles, %0d errors", n_full_cycles, n_bad);
		if (n_bad == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
